// ----- hdl/avkf_pkg.sv -----
// ----------------------------------------------------------------------------
// avkf_pkg
// Shared types, constants and the micro-program of the altitude/velocity
// Kalman filter.
// ----------------------------------------------------------------------------
package avkf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // Working word: 48-bit covariance range plus headroom for one unclipped sum.
  localparam int DW = 50;
  localparam int MW = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 1'b1;

  localparam logic [1:0] MODE_RESTART   = 2'd0;
  localparam logic [1:0] MODE_PRED_CORR = 2'd1;
  localparam logic [1:0] MODE_PRED_ONLY = 2'd2;

  typedef enum logic [3:0] {
    K_MUL, K_DIV, K_ADD48, K_SUB48, K_ADD32, K_ADDW, K_MOV, K_SKIPLE, K_CHKCOR, K_END
  } kind_t;

  // Codes below 16 address the register file; the rest select fixed sources.
  typedef enum logic [4:0] {
    SRC_ALT = 5'd0, SRC_VEL = 5'd1, SRC_P00 = 5'd2, SRC_P01 = 5'd3,
    SRC_P10 = 5'd4, SRC_P11 = 5'd5,
    SRC_T0 = 5'd6, SRC_T1 = 5'd7, SRC_T2 = 5'd8, SRC_T3 = 5'd9, SRC_T4 = 5'd10,
    SRC_T5 = 5'd11, SRC_T6 = 5'd12, SRC_T7 = 5'd13, SRC_T8 = 5'd14,
    SRC_DT = 5'd16, SRC_ACC = 5'd17, SRC_Z = 5'd18, SRC_QV = 5'd19, SRC_RV = 5'd20,
    SRC_HALF = 5'd21, SRC_QUARTER = 5'd22, SRC_ZERO = 5'd23, SRC_ONE = 5'd24
  } src_t;

  localparam int NREG = 15;

  typedef logic [5:0] pc_t;
  localparam pc_t PC_PREDICT = 6'd0;
  localparam pc_t PC_DONE    = 6'd48;
  localparam pc_t PC_RESTART = 6'd49;

  typedef struct packed {
    kind_t kind;
    src_t  dst;
    src_t  a;
    src_t  b;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic publish;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic skip;
  } sts_t;

  typedef enum logic [2:0] {ST_FETCH, ST_WAIT, ST_RESULT, ST_IDLE} state_t;

  function automatic uop_t mk(kind_t k, src_t d, src_t a, src_t b);
    uop_t u;
    u.kind = k;
    u.dst  = d;
    u.a    = a;
    u.b    = b;
    return u;
  endfunction

  function automatic uop_t ucode(pc_t pc);
    uop_t u;
    unique case (pc)
      // Prediction.
      6'd0:  u = mk(K_MUL,   SRC_T0,  SRC_DT,  SRC_DT);
      6'd1:  u = mk(K_MUL,   SRC_T1,  SRC_T0,  SRC_DT);
      6'd2:  u = mk(K_MUL,   SRC_T2,  SRC_T1,  SRC_DT);
      6'd3:  u = mk(K_MUL,   SRC_T3,  SRC_ACC, SRC_DT);
      6'd4:  u = mk(K_MUL,   SRC_T4,  SRC_VEL, SRC_DT);
      6'd5:  u = mk(K_MUL,   SRC_T5,  SRC_T3,  SRC_DT);
      6'd6:  u = mk(K_MUL,   SRC_T5,  SRC_T5,  SRC_HALF);
      6'd7:  u = mk(K_ADDW,  SRC_T4,  SRC_ALT, SRC_T4);
      6'd8:  u = mk(K_ADD32, SRC_ALT, SRC_T4,  SRC_T5);
      6'd9:  u = mk(K_ADD32, SRC_VEL, SRC_VEL, SRC_T3);
      6'd10: u = mk(K_MUL,   SRC_T6,  SRC_DT,  SRC_P10);
      6'd11: u = mk(K_ADD48, SRC_T6,  SRC_P00, SRC_T6);
      6'd12: u = mk(K_MUL,   SRC_T7,  SRC_DT,  SRC_P11);
      6'd13: u = mk(K_ADD48, SRC_T7,  SRC_P01, SRC_T7);
      6'd14: u = mk(K_MUL,   SRC_T8,  SRC_P11, SRC_DT);
      6'd15: u = mk(K_ADD48, SRC_P10, SRC_P10, SRC_T8);
      6'd16: u = mk(K_MUL,   SRC_T8,  SRC_T7,  SRC_DT);
      6'd17: u = mk(K_ADD48, SRC_P00, SRC_T6,  SRC_T8);
      6'd18: u = mk(K_MOV,   SRC_P01, SRC_T7,  SRC_ZERO);
      6'd19: u = mk(K_MUL,   SRC_T8,  SRC_QUARTER, SRC_T2);
      6'd20: u = mk(K_MUL,   SRC_T8,  SRC_T8,  SRC_QV);
      6'd21: u = mk(K_ADD48, SRC_P00, SRC_P00, SRC_T8);
      6'd22: u = mk(K_MUL,   SRC_T8,  SRC_HALF, SRC_T1);
      6'd23: u = mk(K_MUL,   SRC_T8,  SRC_T8,  SRC_QV);
      6'd24: u = mk(K_ADD48, SRC_P01, SRC_P01, SRC_T8);
      6'd25: u = mk(K_ADD48, SRC_P10, SRC_P10, SRC_T8);
      6'd26: u = mk(K_MUL,   SRC_T8,  SRC_T0,  SRC_QV);
      6'd27: u = mk(K_ADD48, SRC_P11, SRC_P11, SRC_T8);
      6'd28: u = mk(K_CHKCOR, SRC_T0, SRC_ZERO, SRC_ZERO);
      // Correction.
      6'd29: u = mk(K_SUB48, SRC_T0,  SRC_Z,   SRC_ALT);
      6'd30: u = mk(K_ADD48, SRC_T1,  SRC_P00, SRC_RV);
      6'd31: u = mk(K_SKIPLE, SRC_T1, SRC_T1,  SRC_ZERO);
      6'd32: u = mk(K_DIV,   SRC_T2,  SRC_P00, SRC_T1);
      6'd33: u = mk(K_DIV,   SRC_T3,  SRC_P10, SRC_T1);
      6'd34: u = mk(K_MUL,   SRC_T4,  SRC_T2,  SRC_T0);
      6'd35: u = mk(K_ADD32, SRC_ALT, SRC_ALT, SRC_T4);
      6'd36: u = mk(K_MUL,   SRC_T4,  SRC_T3,  SRC_T0);
      6'd37: u = mk(K_ADD32, SRC_VEL, SRC_VEL, SRC_T4);
      6'd38: u = mk(K_MUL,   SRC_T4,  SRC_T2,  SRC_P00);
      6'd39: u = mk(K_SUB48, SRC_T5,  SRC_P00, SRC_T4);
      6'd40: u = mk(K_MUL,   SRC_T4,  SRC_T2,  SRC_P01);
      6'd41: u = mk(K_SUB48, SRC_T6,  SRC_P01, SRC_T4);
      6'd42: u = mk(K_MUL,   SRC_T4,  SRC_T3,  SRC_P00);
      6'd43: u = mk(K_SUB48, SRC_P10, SRC_P10, SRC_T4);
      6'd44: u = mk(K_MUL,   SRC_T4,  SRC_T3,  SRC_P01);
      6'd45: u = mk(K_SUB48, SRC_P11, SRC_P11, SRC_T4);
      6'd46: u = mk(K_MOV,   SRC_P00, SRC_T5,  SRC_ZERO);
      6'd47: u = mk(K_MOV,   SRC_P01, SRC_T6,  SRC_ZERO);
      6'd48: u = mk(K_END,   SRC_T0,  SRC_ZERO, SRC_ZERO);
      // Restart.
      6'd49: u = mk(K_MOV,   SRC_ALT, SRC_Z,    SRC_ZERO);
      6'd50: u = mk(K_MOV,   SRC_VEL, SRC_ZERO, SRC_ZERO);
      6'd51: u = mk(K_MOV,   SRC_P00, SRC_ONE,  SRC_ZERO);
      6'd52: u = mk(K_MOV,   SRC_P01, SRC_ZERO, SRC_ZERO);
      6'd53: u = mk(K_MOV,   SRC_P10, SRC_ZERO, SRC_ZERO);
      6'd54: u = mk(K_MOV,   SRC_P11, SRC_ONE,  SRC_ZERO);
      default: u = mk(K_END, SRC_T0,  SRC_ZERO, SRC_ZERO);
    endcase
    return u;
  endfunction

endpackage

// ----- hdl/avkf_if.sv -----
// ----------------------------------------------------------------------------
// avkf_in_if / avkf_out_if
// Valid/ready channels for filter samples and filter results.
// ----------------------------------------------------------------------------
interface avkf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] vertical_accel;
  logic signed [31:0] altitude_sample;
  logic [15:0]        time_step;

  modport source(output valid, mode, vertical_accel, altitude_sample, time_step,
                 input ready);
  modport sink(input valid, mode, vertical_accel, altitude_sample, time_step,
               output ready);
endinterface

interface avkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] altitude_estimate;
  logic signed [31:0] velocity_estimate;
  logic [31:0]        altitude_uncertainty;
  logic               saturated;

  modport source(output valid, altitude_estimate, velocity_estimate,
                 altitude_uncertainty, saturated, input ready);
  modport sink(input valid, altitude_estimate, velocity_estimate,
               altitude_uncertainty, saturated, output ready);
endinterface

// ----- hdl/avkf_datapath.sv -----
// ----------------------------------------------------------------------------
// avkf_datapath
// Register file, shared multiplier, restoring divider and saturating adder.
// ----------------------------------------------------------------------------
module avkf_datapath #(
  parameter int FRAC_BITS = avkf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  avkf_pkg::cmd_t                      cmd,
  output avkf_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [avkf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [avkf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [31:0]                  in_accel,
  input  logic signed [31:0]                  in_sample,
  input  logic [15:0]                         in_dt,
  output logic signed [31:0]                  out_alt,
  output logic signed [31:0]                  out_vel,
  output logic [31:0]                         out_unc,
  output logic                                out_sat
);

  localparam int DW = avkf_pkg::DW;
  localparam int MW = avkf_pkg::MW;
  localparam int PW = 2 * MW;
  localparam int RW = PW + 1;
  localparam int QW = MW + FRAC_BITS;
  localparam int CW = $clog2(QW + 2);
  localparam int HW = MW / 2;

  localparam logic [DW-1:0] C_ONE     = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [DW-1:0] C_HALF    = {{(DW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [DW-1:0] C_QUARTER = {{(DW-1){1'b0}}, 1'b1} << (FRAC_BITS - 2);
  localparam logic [RW-1:0] RND_ADD   = {{(RW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [RW-1:0] LIM_POS   = {{(RW-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic [RW-1:0] LIM_NEG   = {{(RW-MW){1'b0}}, 1'b1, {(MW-1){1'b0}}};
  localparam logic [CW-1:0] MUL_LAST  = CW'(4);
  localparam logic [CW-1:0] DIV_LAST  = CW'(QW + 1);

  logic signed [DW-1:0] mem [avkf_pkg::NREG];

  logic [DW-1:0]  rda_r, rdb_r, opa, opb;
  avkf_pkg::uop_t uop_r;
  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [PW-1:0]  acc_r;
  logic [MW:0]    rem_r;
  logic [QW-1:0]  dd_r, q_r;
  logic           clip_r;
  logic [31:0]    qv_r, rv_r;
  logic [31:0]    accel_r, z_r;
  logic [15:0]    dt_r;
  logic [31:0]    alt_r, vel_r;
  logic [MW-1:0]  p00_r;
  logic [31:0]    out_alt_r, out_vel_r, out_unc_r;
  logic           out_sat_r;

  function automatic logic [DW-1:0] pick(avkf_pkg::src_t s, logic [DW-1:0] rd,
                                         logic [15:0] dt, logic [31:0] ac,
                                         logic [31:0] z, logic [31:0] qv,
                                         logic [31:0] rv);
    logic [DW-1:0] v;
    case (s)
      avkf_pkg::SRC_DT:      v = {{(DW-16){1'b0}}, dt};
      avkf_pkg::SRC_ACC:     v = {{(DW-32){ac[31]}}, ac};
      avkf_pkg::SRC_Z:       v = {{(DW-32){z[31]}}, z};
      avkf_pkg::SRC_QV:      v = {{(DW-32){1'b0}}, qv};
      avkf_pkg::SRC_RV:      v = {{(DW-32){1'b0}}, rv};
      avkf_pkg::SRC_HALF:    v = C_HALF;
      avkf_pkg::SRC_QUARTER: v = C_QUARTER;
      avkf_pkg::SRC_ZERO:    v = '0;
      avkf_pkg::SRC_ONE:     v = C_ONE;
      default:               v = rd;
    endcase
    return v;
  endfunction

  // Clip a magnitude to the 48-bit signed range and reapply the sign.
  function automatic logic [DW:0] sres(logic [RW-1:0] r, logic neg);
    logic [RW-1:0] lim;
    logic [RW-1:0] m;
    logic [DW-1:0] v;
    logic          c;
    lim = neg ? LIM_NEG : LIM_POS;
    c   = r > lim;
    m   = c ? lim : r;
    v   = {{(DW-MW){1'b0}}, m[MW-1:0]};
    return {c, neg ? (~v + 1'b1) : v};
  endfunction

  function automatic logic [DW:0] sat(logic [DW:0] x, logic to32);
    logic signed [DW:0] sx;
    logic signed [DW:0] hi;
    logic signed [DW:0] lo;
    sx = x;
    hi = to32 ? (DW+1)'(64'sd2147483647) : (DW+1)'(64'sd140737488355327);
    lo = to32 ? (DW+1)'(-64'sd2147483648) : (DW+1)'(-64'sd140737488355328);
    if (sx > hi) begin
      return {1'b1, hi[DW-1:0]};
    end else if (sx < lo) begin
      return {1'b1, lo[DW-1:0]};
    end
    return {1'b0, x[DW-1:0]};
  endfunction

  assign opa = pick(uop_r.a, rda_r, dt_r, accel_r, z_r, qv_r, rv_r);
  assign opb = pick(uop_r.b, rdb_r, dt_r, accel_r, z_r, qv_r, rv_r);

  logic [DW-1:0]  ma_full, mb_full;
  logic [MW-1:0]  ma, mb;
  logic [HW-1:0]  a_ch, b_ch;
  logic [MW-1:0]  pp;
  logic [PW-1:0]  pp_add;
  logic [RW-1:0]  rnd;
  logic [MW:0]    rem_sh;
  logic           ge;
  logic [DW:0]    sum_a, sum_s;
  logic           last;
  logic [DW:0]    res;

  always_comb begin
    ma_full = opa[DW-1] ? (~opa + 1'b1) : opa;
    mb_full = opb[DW-1] ? (~opb + 1'b1) : opb;
    ma      = ma_full[MW-1:0];
    mb      = mb_full[MW-1:0];
    a_ch    = cnt_r[1] ? ma[MW-1:HW] : ma[HW-1:0];
    b_ch    = cnt_r[0] ? mb[MW-1:HW] : mb[HW-1:0];
    pp      = a_ch * b_ch;
    unique case ({cnt_r[1], cnt_r[0]})
      2'b00:         pp_add = {{(PW-MW){1'b0}}, pp};
      2'b01, 2'b10:  pp_add = {{(PW-MW){1'b0}}, pp} << HW;
      default:       pp_add = {{(PW-MW){1'b0}}, pp} << MW;
    endcase
    rnd    = ({1'b0, acc_r} + RND_ADD) >> FRAC_BITS;
    rem_sh = {rem_r[MW-1:0], dd_r[QW-1]};
    ge     = rem_sh >= opb[MW:0];
    sum_a  = {opa[DW-1], opa} + {opb[DW-1], opb};
    sum_s  = {opa[DW-1], opa} - {opb[DW-1], opb};
  end

  always_comb begin
    unique case (uop_r.kind)
      avkf_pkg::K_MUL: begin
        last = cnt_r == MUL_LAST;
        res  = sres(rnd, opa[DW-1] ^ opb[DW-1]);
      end
      avkf_pkg::K_DIV: begin
        last = cnt_r == DIV_LAST;
        res  = sres({{(RW-QW){1'b0}}, q_r}, opa[DW-1]);
      end
      avkf_pkg::K_ADD48: begin
        last = cnt_r == '0;
        res  = sat(sum_a, 1'b0);
      end
      avkf_pkg::K_SUB48: begin
        last = cnt_r == '0;
        res  = sat(sum_s, 1'b0);
      end
      avkf_pkg::K_ADD32: begin
        last = cnt_r == '0;
        res  = sat(sum_a, 1'b1);
      end
      avkf_pkg::K_ADDW: begin
        last = cnt_r == '0;
        res  = {1'b0, sum_a[DW-1:0]};
      end
      default: begin
        last = cnt_r == '0;
        res  = {1'b0, opa};
      end
    endcase
    sts.done = busy_r && last;
    sts.skip = (uop_r.kind == avkf_pkg::K_SKIPLE) && (opa[DW-1] || (opa == '0));
  end

  // Register file: one write port, two registered reads.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rda_r <= mem[cmd.uop.a[3:0]];
      rdb_r <= mem[cmd.uop.b[3:0]];
    end
    if (sts.done && (uop_r.kind != avkf_pkg::K_SKIPLE)) begin
      mem[uop_r.dst[3:0]] <= res[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      clip_r <= 1'b0;
      qv_r   <= 32'(C_ONE);
      rv_r   <= 32'(C_ONE);
      z_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          avkf_pkg::CFG_PROC_NOISE: qv_r <= cfg_wdata;
          avkf_pkg::CFG_MEAS_NOISE: rv_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        z_r    <= in_sample;
        clip_r <= 1'b0;
      end else if (sts.done && res[DW]) begin
        clip_r <= 1'b1;
      end
      if (cmd.issue) begin
        busy_r <= 1'b1;
      end else if (sts.done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accel_r <= in_accel;
      dt_r    <= in_dt;
    end
    if (cmd.issue) begin
      uop_r <= cmd.uop;
      cnt_r <= '0;
      acc_r <= '0;
    end else if (busy_r && !last) begin
      cnt_r <= cnt_r + 1'b1;
      if (uop_r.kind == avkf_pkg::K_MUL) begin
        acc_r <= acc_r + pp_add;
      end
      if (uop_r.kind == avkf_pkg::K_DIV) begin
        if (cnt_r == '0) begin
          rem_r <= '0;
          q_r   <= '0;
          dd_r  <= {ma, {FRAC_BITS{1'b0}}};
        end else begin
          rem_r <= ge ? (rem_sh - opb[MW:0]) : rem_sh;
          q_r   <= {q_r[QW-2:0], ge};
          dd_r  <= {dd_r[QW-2:0], 1'b0};
        end
      end
    end
    if (sts.done && (uop_r.kind != avkf_pkg::K_SKIPLE)) begin
      if (uop_r.dst == avkf_pkg::SRC_ALT) alt_r <= res[31:0];
      if (uop_r.dst == avkf_pkg::SRC_VEL) vel_r <= res[31:0];
      if (uop_r.dst == avkf_pkg::SRC_P00) p00_r <= res[MW-1:0];
    end
    if (cmd.publish) begin
      out_alt_r <= alt_r;
      out_vel_r <= vel_r;
      out_sat_r <= clip_r;
      if (p00_r[MW-1]) begin
        out_unc_r <= '0;
      end else if (|p00_r[MW-2:32]) begin
        out_unc_r <= '1;
      end else begin
        out_unc_r <= p00_r[31:0];
      end
    end
  end

  assign out_alt = out_alt_r;
  assign out_vel = out_vel_r;
  assign out_unc = out_unc_r;
  assign out_sat = out_sat_r;

endmodule

// ----- hdl/avkf_ctrl.sv -----
// ----------------------------------------------------------------------------
// avkf_ctrl
// Sequencer that walks the micro-program and runs the channel handshakes.
// ----------------------------------------------------------------------------
module avkf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_mode,
  output logic           out_valid,
  input  logic           out_ready,
  output avkf_pkg::cmd_t cmd,
  input  avkf_pkg::sts_t sts
);

  avkf_pkg::state_t state_r, state_nxt;
  avkf_pkg::pc_t    pc_r, pc_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic             init_r, init_nxt;
  logic             out_valid_r, out_valid_nxt;
  avkf_pkg::uop_t   uop;
  logic             slot_free;

  assign uop       = avkf_pkg::ucode(pc_r);
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= avkf_pkg::ST_FETCH;
      pc_r        <= avkf_pkg::PC_RESTART;
      mode_r      <= avkf_pkg::MODE_RESTART;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      mode_r      <= mode_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    mode_nxt      = mode_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      avkf_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          state_nxt = avkf_pkg::ST_FETCH;
          unique case (in_mode)
            avkf_pkg::MODE_RESTART:   pc_nxt = avkf_pkg::PC_RESTART;
            avkf_pkg::MODE_PRED_CORR: pc_nxt = avkf_pkg::PC_PREDICT;
            avkf_pkg::MODE_PRED_ONLY: pc_nxt = avkf_pkg::PC_PREDICT;
            default:                  pc_nxt = avkf_pkg::PC_DONE;
          endcase
        end
      end
      avkf_pkg::ST_FETCH: begin
        priority if (uop.kind == avkf_pkg::K_END) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? avkf_pkg::ST_IDLE : avkf_pkg::ST_RESULT;
        end else if (uop.kind == avkf_pkg::K_CHKCOR) begin
          pc_nxt = (mode_r == avkf_pkg::MODE_PRED_CORR) ? pc_r + 1'b1
                                                        : avkf_pkg::PC_DONE;
        end else begin
          state_nxt = avkf_pkg::ST_WAIT;
        end
      end
      avkf_pkg::ST_WAIT: begin
        if (sts.done) begin
          pc_nxt    = sts.skip ? avkf_pkg::PC_DONE : pc_r + 1'b1;
          state_nxt = avkf_pkg::ST_FETCH;
        end
      end
      avkf_pkg::ST_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = avkf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = avkf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = state_r == avkf_pkg::ST_IDLE;
    out_valid   = out_valid_r;
    cmd.uop     = uop;
    cmd.load    = (state_r == avkf_pkg::ST_IDLE) && in_valid;
    cmd.issue   = (state_r == avkf_pkg::ST_FETCH) && (uop.kind != avkf_pkg::K_END)
                  && (uop.kind != avkf_pkg::K_CHKCOR);
    cmd.publish = (state_r == avkf_pkg::ST_RESULT) && slot_free;
  end

endmodule

// ----- hdl/altitude_velocity_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// altitude_velocity_kalman_filter
// Two-state fixed-point Kalman filter for altitude and vertical velocity.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Contents
//  in_chan   sink       valid/ready    mode, vertical_accel, altitude_sample,
//                                      time_step
//  out_chan  source     valid/ready    altitude_estimate, velocity_estimate,
//                                      altitude_uncertainty, saturated
//  cfg_*     write      cfg_we         process (0) / measurement (1) noise
//
// One sample is processed at a time. The cost is set by the shared multiplier,
// which builds each product from four 24 by 24 bit partial products, and by
// the restoring divider, which produces one gain bit per cycle.
// After reset the sequencer runs the restart program once to load the
// initial state; in_chan.ready stays low until it is done.
// A finished result sits in the output register until its transfer, while
// the next sample is already being taken in.
//
module altitude_velocity_kalman_filter #(
  parameter int FRAC_BITS = avkf_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  avkf_in_if.sink                          in_chan,
  avkf_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [avkf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [avkf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  avkf_pkg::cmd_t cmd;
  avkf_pkg::sts_t sts;

  // The controller owns the handshakes and the micro-program counter.
  avkf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_mode   (in_chan.mode),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the state, the covariance and the noise registers.
  avkf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_accel  (in_chan.vertical_accel),
    .in_sample (in_chan.altitude_sample),
    .in_dt     (in_chan.time_step),
    .out_alt   (out_chan.altitude_estimate),
    .out_vel   (out_chan.velocity_estimate),
    .out_unc   (out_chan.altitude_uncertainty),
    .out_sat   (out_chan.saturated)
  );

endmodule

// ----- hdl/avkf_checker.sv -----
// ----------------------------------------------------------------------------
// avkf_checker
// Port-level checks of the filter's channel behavior.
// ----------------------------------------------------------------------------
module avkf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_alt,
  input logic [31:0] out_unc
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_alt) && $stable(out_unc))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a sample in work");

endmodule

bind altitude_velocity_kalman_filter avkf_checker u_avkf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_alt   (out_chan.altitude_estimate),
  .out_unc   (out_chan.altitude_uncertainty)
);
